FILE: sv/banked_mmu_flash_command_sequencer_assert.svh
// ----------------------------------------------------------------------------
// banked mmu flash command sequencer assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BANKED_MMU_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define BANKED_MMU_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BMFCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmfcs same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BMFCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmfcs next-cycle check failed");

`endif

FILE: sv/bmfcs_pkg.sv
// ----------------------------------------------------------------------------
// bmfcs_pkg
// types, constants and command-sequence tables shared by the sequencer blocks
// ----------------------------------------------------------------------------
package bmfcs_pkg;

  // field widths
  localparam int PAGE_W  = 8;
  localparam int MASK_W  = 4;
  localparam int PCNT_W  = 9;
  localparam int PA_W    = 22;
  localparam int LEN_W   = 23;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int A12_W   = 12;
  localparam int ENTRY_W = A12_W + DATA_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // command history
  localparam int HIST_DEPTH = 6;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);
  localparam int SEQ_LEN_MAX = 6;
  localparam int NUM_SEQ = 3;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BANK0_PAGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK1_PAGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK2_PAGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BANK3_PAGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_MASK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCKED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT  = 3'd6;

  // config reset values
  localparam logic [MASK_W-1:0] FLASH_MASK_RST = 4'd14;
  localparam logic [PCNT_W-1:0] PAGE_COUNT_RST = 9'd32;
  localparam logic [PCNT_W-1:0] PAGE_COUNT_MAX = 9'd256;

  // access kinds on the cpu bus
  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_FORCED = 2'd2;

  // memory operation codes
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_READ    = 3'd1,
    OP_STORE   = 3'd2,
    OP_PROGRAM = 3'd3,
    OP_ERASE   = 3'd4
  } mem_op_t;

  // classification made by the front end
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_SEQ   = 2'd3
  } item_kind_t;

  // sequence table rows
  localparam int SEQ_PROGRAM = 0;
  localparam int SEQ_CHIP    = 1;
  localparam int SEQ_SECTOR  = 2;

  localparam int SEQ_LEN [NUM_SEQ] = '{4, 6, 6};

  localparam logic [ENTRY_W-1:0] SEQ_ENTRY [NUM_SEQ][SEQ_LEN_MAX] = '{
    '{20'hAAAAA, 20'h55555, 20'hAAAA0, 20'h00000, 20'h00000, 20'h00000},
    '{20'hAAAAA, 20'h55555, 20'hAAA80, 20'hAAAAA, 20'h55555, 20'hAAA10},
    '{20'hAAAAA, 20'h55555, 20'hAAA80, 20'hAAAAA, 20'h55555, 20'h00000}
  };

  localparam logic [ENTRY_W-1:0] SEQ_CARE [NUM_SEQ][SEQ_LEN_MAX] = '{
    '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h00000, 20'h00000, 20'h00000},
    '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF},
    '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h00000}
  };

  // sector sizes
  localparam logic [LEN_W-1:0] LEN_64K = 23'h10000;
  localparam logic [LEN_W-1:0] LEN_32K = 23'h08000;
  localparam logic [LEN_W-1:0] LEN_16K = 23'h04000;
  localparam logic [LEN_W-1:0] LEN_8K  = 23'h02000;

  // cpu bus request
  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] cpu_address;
    logic [DATA_W-1:0] write_data;
  } in_req_t;

  // memory operation result
  typedef struct packed {
    logic [2:0]        mem_op;
    logic              mem_is_flash;
    logic [PA_W-1:0]   phys_address;
    logic [DATA_W-1:0] mem_data;
    logic [LEN_W-1:0]  erase_length;
  } out_rsp_t;

  // classified request held in the queue
  typedef struct packed {
    item_kind_t        kind;
    logic              is_flash;
    logic [PA_W-1:0]   pa;
    logic [DATA_W-1:0] data;
    logic [A12_W-1:0]  addr12;
  } cls_item_t;

endpackage

FILE: sv/bmfcs_front.sv
// ----------------------------------------------------------------------------
// bmfcs_front
// config registers, bank mapping and request classification
// ----------------------------------------------------------------------------
module bmfcs_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bmfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmfcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bmfcs_pkg::in_req_t               in_req,
  output logic                             push_valid,
  input  logic                             push_full,
  output bmfcs_pkg::cls_item_t             push_item,
  output logic [bmfcs_pkg::PCNT_W-1:0]     page_count
);
  import bmfcs_pkg::*;

  logic [PAGE_W-1:0] page_r [4];
  logic [MASK_W-1:0] mask_r;
  logic              unlocked_r;
  logic [PCNT_W-1:0] pcnt_r;

  logic [1:0]        bank;
  logic              fl;
  item_kind_t        kind;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r[0]  <= '0;
      page_r[1]  <= '0;
      page_r[2]  <= '0;
      page_r[3]  <= '0;
      mask_r     <= FLASH_MASK_RST;
      unlocked_r <= 1'b0;
      pcnt_r     <= PAGE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BANK0_PAGE: page_r[0]  <= cfg_wdata[PAGE_W-1:0];
        REG_BANK1_PAGE: page_r[1]  <= cfg_wdata[PAGE_W-1:0];
        REG_BANK2_PAGE: page_r[2]  <= cfg_wdata[PAGE_W-1:0];
        REG_BANK3_PAGE: page_r[3]  <= cfg_wdata[PAGE_W-1:0];
        REG_FLASH_MASK: mask_r     <= cfg_wdata[MASK_W-1:0];
        REG_UNLOCKED:   unlocked_r <= cfg_wdata[0];
        REG_PAGE_COUNT: pcnt_r     <= cfg_wdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // bank lookup
  assign bank = in_req.cpu_address[ADDR_W-1:ADDR_W-2];
  assign fl   = mask_r[bank];

  // classify the access
  always_comb begin
    unique case (in_req.func)
      FUNC_READ:   kind = KIND_READ;
      FUNC_FORCED: kind = KIND_STORE;
      FUNC_WRITE: begin
        if (!fl) begin
          kind = KIND_STORE;
        end else if (!unlocked_r) begin
          kind = KIND_NONE;
        end else begin
          kind = KIND_SEQ;
        end
      end
      default:     kind = KIND_NONE;
    endcase
  end

  assign push_item.kind     = kind;
  assign push_item.is_flash = fl;
  assign push_item.pa       = {page_r[bank], in_req.cpu_address[13:0]};
  assign push_item.data     = in_req.write_data;
  assign push_item.addr12   = in_req.cpu_address[A12_W-1:0];

  assign push_valid = in_valid;
  assign in_stall   = push_full;
  assign page_count = pcnt_r;

endmodule

FILE: sv/bmfcs_queue.sv
// ----------------------------------------------------------------------------
// bmfcs_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module bmfcs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_full,
  input  bmfcs_pkg::cls_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_take,
  output bmfcs_pkg::cls_item_t pop_item
);
  import bmfcs_pkg::*;

  cls_item_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_full = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_take;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/bmfcs_back.sv
// ----------------------------------------------------------------------------
// bmfcs_back
// command history, sequence match and result register
// ----------------------------------------------------------------------------
module bmfcs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_take,
  input  bmfcs_pkg::cls_item_t         pop_item,
  input  logic [bmfcs_pkg::PCNT_W-1:0] page_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bmfcs_pkg::out_rsp_t          out_rsp
);
  import bmfcs_pkg::*;

  logic [ENTRY_W-1:0]    hist_r [HIST_DEPTH];
  logic [HIST_CNT_W-1:0] hist_cnt_r, hist_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_rsp_t              out_rsp_r, out_rsp_nxt;

  logic [HIST_CNT_W-1:0] cnt_base;
  logic [HIST_CNT_W-1:0] cnt_new;
  logic [ENTRY_W-1:0]    entry_new;
  logic [ENTRY_W-1:0]    view [SEQ_LEN_MAX];
  logic [NUM_SEQ-1:0]    complete;
  logic [NUM_SEQ-1:0]    partial;
  logic                  hit_c;
  logic                  hit_p;
  logic                  hit;
  logic                  last_sector;
  logic [LEN_W-1:0]      sect_len;
  logic [PA_W-1:0]       sect_mask;
  logic [PCNT_W-1:0]     pages;

  assign pop_take = pop_valid && (!out_valid_r || !out_stall);

  // history slot for the incoming write
  assign cnt_base  = (hist_cnt_r >= HIST_CNT_W'(HIST_DEPTH)) ? '0 : hist_cnt_r;
  assign cnt_new   = cnt_base + 1'b1;
  assign entry_new = {pop_item.addr12, pop_item.data};

  // history as it looks with the new write in place
  always_comb begin
    for (int i = 0; i < SEQ_LEN_MAX; i++) begin
      view[i] = (cnt_base == HIST_CNT_W'(i)) ? entry_new : hist_r[i];
    end
  end

  // match every sequence against the history in parallel
  always_comb begin
    for (int s = 0; s < NUM_SEQ; s++) begin
      hit_c = 1'b1;
      hit_p = 1'b1;
      for (int i = 0; i < SEQ_LEN_MAX; i++) begin
        hit = ((view[i] & SEQ_CARE[s][i]) == SEQ_ENTRY[s][i]);
        if (i < SEQ_LEN[s]) begin
          hit_c = hit_c && hit;
          if (HIST_CNT_W'(i) < cnt_new) begin
            hit_p = hit_p && hit;
          end
        end
      end
      complete[s] = (cnt_new >= HIST_CNT_W'(SEQ_LEN[s])) && hit_c;
      partial[s]  = (cnt_new <  HIST_CNT_W'(SEQ_LEN[s])) && hit_p;
    end
  end

  // sector size, with sub-sectors in the last 64k sector
  assign last_sector = (({1'b0, pop_item.pa[PA_W-1:16]} + 7'd1) ==
                        page_count[PCNT_W-1:2]);
  always_comb begin
    if (!last_sector) begin
      sect_len = LEN_64K;
    end else begin
      unique case (pop_item.pa[15:13])
        3'd0, 3'd1, 3'd2, 3'd3: sect_len = LEN_32K;
        3'd4, 3'd5:             sect_len = LEN_8K;
        default:                sect_len = LEN_16K;
      endcase
    end
  end
  assign sect_mask = ~(PA_W'(sect_len - 1'b1));

  // chip size in pages, saturated
  assign pages = (page_count > PAGE_COUNT_MAX) ? PAGE_COUNT_MAX : page_count;

  // result and history count for the popped request
  always_comb begin
    out_rsp_nxt  = '0;
    hist_cnt_nxt = hist_cnt_r;
    unique case (pop_item.kind)
      KIND_READ: begin
        out_rsp_nxt.mem_op       = OP_READ;
        out_rsp_nxt.mem_is_flash = pop_item.is_flash;
        out_rsp_nxt.phys_address = pop_item.pa;
        if (pop_item.is_flash) begin
          hist_cnt_nxt = '0;
        end
      end
      KIND_STORE: begin
        out_rsp_nxt.mem_op       = OP_STORE;
        out_rsp_nxt.mem_is_flash = pop_item.is_flash;
        out_rsp_nxt.phys_address = pop_item.pa;
        out_rsp_nxt.mem_data     = pop_item.data;
      end
      KIND_SEQ: begin
        priority if (complete[SEQ_PROGRAM]) begin
          hist_cnt_nxt             = '0;
          out_rsp_nxt.mem_op       = OP_PROGRAM;
          out_rsp_nxt.mem_is_flash = 1'b1;
          out_rsp_nxt.phys_address = pop_item.pa;
          out_rsp_nxt.mem_data     = pop_item.data;
        end else if (complete[SEQ_CHIP]) begin
          hist_cnt_nxt             = '0;
          out_rsp_nxt.mem_op       = OP_ERASE;
          out_rsp_nxt.mem_is_flash = 1'b1;
          out_rsp_nxt.erase_length = {pages, 14'b0};
        end else if (complete[SEQ_SECTOR]) begin
          hist_cnt_nxt             = '0;
          out_rsp_nxt.mem_op       = OP_ERASE;
          out_rsp_nxt.mem_is_flash = 1'b1;
          out_rsp_nxt.phys_address = pop_item.pa & sect_mask;
          out_rsp_nxt.erase_length = sect_len;
        end else if (partial == '0) begin
          hist_cnt_nxt = '0;
        end else begin
          // still a prefix of some sequence, keep the write
          hist_cnt_nxt = cnt_new;
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hist_cnt_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop_take) begin
        hist_cnt_r <= hist_cnt_nxt;
      end
    end
  end

  // payload and history entries
  always_ff @(posedge clk) begin
    if (pop_take) begin
      out_rsp_r <= out_rsp_nxt;
      if (pop_item.kind == KIND_SEQ) begin
        hist_r[cnt_base[HIST_IDX_W-1:0]] <= entry_new;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: sv/banked_mmu_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// banked_mmu_flash_command_sequencer
// banked address mapping with a flash command-sequence decoder
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid / in_stall / in_req) takes one cpu bus request:
//   read, write or forced write. every request gives exactly one result on
//   the out channel (out_valid / out_stall / out_rsp): none, read, store,
//   program and or an erase range, in request order.
//   config port (cfg_we / cfg_index / cfg_wdata) writes bank pages, the
//   flash bank mask, the unlock bit and the flash page count; write it only
//   while no request is in flight.
//   an accepted request is first written into the queue; the sequence
//   match then loads the result register from the queue head and raises
//   out_valid with it.
//   throughput is one request per cycle while out_stall is low, set by a
//   combinational parallel compare of six history entries to the sequences.
//   while out_stall is high the result register holds and the two-entry
//   queue fills; in_stall rises once the queue is full.
//   reset clears the queue, the result valid flag and the history count
//   and loads the config reset values.
// ----------------------------------------------------------------------------
`include "banked_mmu_flash_command_sequencer_assert.svh"

module banked_mmu_flash_command_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bmfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmfcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bmfcs_pkg::in_req_t               in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bmfcs_pkg::out_rsp_t              out_rsp
);
  import bmfcs_pkg::*;

  logic              q_push_valid;
  logic              q_full;
  cls_item_t         q_push_item;
  logic              q_pop_valid;
  logic              q_pop;
  cls_item_t         q_pop_item;
  logic [PCNT_W-1:0] page_count;

  // front end: mapping and classification
  bmfcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .push_valid (q_push_valid),
    .push_full  (q_full),
    .push_item  (q_push_item),
    .page_count (page_count)
  );

  // queue between the two halves
  bmfcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_full  (q_full),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_take   (q_pop),
    .pop_item   (q_pop_item)
  );

  // back end: history, sequence match, result register
  bmfcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_pop_valid),
    .pop_take   (q_pop),
    .pop_item   (q_pop_item),
    .page_count (page_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp)
  );

  // a popped request always shows up as a result next cycle
  `BMFCS_ASSERT_NEXT(a_pop_fills_out, q_pop, out_valid)
  // nothing leaves the queue while a stalled result is held
  `BMFCS_ASSERT_SAME(a_no_pop_on_hold, out_valid && out_stall, !q_pop)
  // an empty queue with no new request stays empty
  `BMFCS_ASSERT_NEXT(a_empty_stays, !q_pop_valid && !(in_valid && !in_stall), !q_pop_valid)

endmodule
